// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the reuse-distance histogram.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/udh_pkg.sv =====
// Types and constants of the reuse-distance histogram block.
// No dependencies; imported by the controller, datapath and top level.
package udh_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LIFE_W     = 11;
  localparam int unsigned UNIQ_W     = 17;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned CKPT_W     = 2;
  localparam int unsigned N_CKPT     = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 72;

  // distance is counted in units of 256 writes
  localparam int unsigned DIST_SHIFT = 8;
  // 10 % checkpoint scaled by the 256 unit: bin*2560 > (unique_blocks << k)
  localparam logic [31:0] CKPT_SCALE = 32'd2560;

  localparam logic [CKPT_W-1:0] CKPT_LAST = CKPT_W'(N_CKPT - 1);

  localparam logic [LIFE_W-1:0] LIFE_RST = 11'd2047;
  localparam logic [UNIQ_W-1:0] UNIQ_RST = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIFESPAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_BLOCKS = 2'd1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_W_RD    = 9'b000000100,
    ST_W_UPD   = 9'b000001000,
    ST_W_BRD   = 9'b000010000,
    ST_W_BWR   = 9'b000100000,
    ST_R_WALK  = 9'b001000000,
    ST_R_DRAIN = 9'b010000000,
    ST_R_OUT   = 9'b100000000
  } udh_state_e;

  typedef struct packed {
    logic clr;      // sweep: zero one map entry and one bin
    logic load;     // take the input beat, reset the report walk
    logic map_rd;   // read the block map
    logic map_upd;  // compute the bin, store the sequence, advance it
    logic bin_rd;   // read the selected bin
    logic bin_wr;   // write the incremented bin back
    logic walk;     // read the next bin of the report walk
    logic out_pop;  // result beat taken, move to next checkpoint
  } udh_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic walk_last;
    logic out_last;
  } udh_sts_t;

endpackage

// ===== hw/rtl/udh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the block map and the histogram bins.
module udh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/udh_ctrl.sv =====
// Sequencer of the reuse-distance histogram: clearing sweep, write update
// and report walk. Depends on udh_pkg.
module udh_ctrl
  import udh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  udh_sts_t sts_i,
  output udh_cmd_t cmd_o
);

  udh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == ACT_REPORT) ? ST_R_WALK : ST_W_RD;
        end
      end
      ST_W_RD: begin
        cmd_o.map_rd = 1'b1;
        state_d      = ST_W_UPD;
      end
      ST_W_UPD: begin
        cmd_o.map_upd = 1'b1;
        // first write to a block leaves the histogram alone
        state_d       = sts_i.hit ? ST_W_BRD : ST_IDLE;
      end
      ST_W_BRD: begin
        cmd_o.bin_rd = 1'b1;
        state_d      = ST_W_BWR;
      end
      ST_W_BWR: begin
        cmd_o.bin_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_R_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) state_d = ST_R_DRAIN;
      end
      ST_R_DRAIN: begin
        state_d = ST_R_OUT;
      end
      ST_R_OUT: begin
        if (out_ready_i) begin
          cmd_o.out_pop = 1'b1;
          if (sts_i.out_last) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_R_OUT);

endmodule

// ===== hw/rtl/udh_dp.sv =====
// Datapath of the reuse-distance histogram: block map and bin RAMs,
// sequence counter, config registers and report accumulator.
// Depends on udh_pkg and udh_ram.
module udh_dp
  import udh_pkg::*;
#(
  parameter int unsigned BLOCKS     = 65536,
  parameter int unsigned HIST_BINS  = 2048,
  parameter int unsigned SEQ_BITS   = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udh_cmd_t              cmd_i,
  output udh_sts_t              sts_o,
  input  logic [ADDR_W-1:0]     in_addr_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int unsigned MAP_AW = $clog2(BLOCKS);
  localparam int unsigned HB     = $clog2(HIST_BINS);
  localparam int unsigned CLR_N  = (BLOCKS > HIST_BINS) ? BLOCKS : HIST_BINS;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam logic [31:0] BLK_W  = 32'(BLOCKS);
  localparam logic [SEQ_BITS-1:0]   SEQ_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // address modulo BLOCKS by restoring subtraction; quotient fits in 8 bits
  function automatic logic [31:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [31:0] r;
    r = 32'(a);
    for (int j = 7; j >= 0; j--) begin
      if (r >= (BLK_W << j)) r = r - (BLK_W << j);
    end
    return r;
  endfunction

  // configuration
  logic [LIFE_W-1:0] life_q;
  logic [UNIQ_W-1:0] uniq_q;
  logic [HB-1:0]     lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q <= LIFE_RST;
      uniq_q <= UNIQ_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAX_LIFESPAN)  life_q <= cfg_data_i[LIFE_W-1:0];
      if (cfg_index_i == REG_UNIQUE_BLOCKS) uniq_q <= cfg_data_i[UNIQ_W-1:0];
    end
  end

  always_comb begin
    if (32'(life_q) > 32'(HIST_BINS - 1)) lim = HB'(HIST_BINS - 1);
    else                                   lim = HB'(life_q);
  end

  // clearing sweep after reset
  logic [CLR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // item registers
  logic [31:0]       wrapped;
  logic [MAP_AW-1:0] idx_q;
  logic [HB-1:0]     bin_q, bin_d;

  assign wrapped = wrap_addr(in_addr_i);

  // block map
  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic [SEQ_BITS-1:0] map_wdata, map_rdata;
  logic [SEQ_BITS-1:0] seq_q, seq_inc, diff, dist_units;
  logic                ovf_q;

  assign map_we    = (cmd_i.clr && (32'(clr_cnt_q) < BLK_W)) || cmd_i.map_upd;
  assign map_waddr = cmd_i.clr ? clr_cnt_q[MAP_AW-1:0] : idx_q;
  assign map_wdata = cmd_i.clr ? '0 : seq_q;

  udh_ram #(.WIDTH(SEQ_BITS), .DEPTH(BLOCKS)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (cmd_i.map_rd),
    .raddr_i (idx_q),
    .rdata_o (map_rdata)
  );

  assign diff       = seq_q - map_rdata;
  assign dist_units = diff >> DIST_SHIFT;
  assign seq_inc    = (seq_q != SEQ_MAX) ? seq_q + 1'b1 : seq_q;

  always_comb begin
    if (64'(dist_units) > 64'(lim)) bin_d = lim;
    else                            bin_d = HB'(dist_units);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_BITS'(1);
      ovf_q <= 1'b0;
    end else if (cmd_i.map_upd) begin
      seq_q <= seq_inc;
      if (seq_inc == SEQ_MAX) ovf_q <= 1'b1;
    end
  end

  // histogram bins
  logic                  bin_we;
  logic [HB-1:0]         bin_waddr, bin_raddr;
  logic [COUNT_BITS-1:0] bin_wdata, bin_rdata, bin_inc;
  logic [HB-1:0]         rptr_q;

  assign bin_inc   = (bin_rdata == COUNT_MAX) ? bin_rdata : bin_rdata + 1'b1;
  assign bin_we    = (cmd_i.clr && (32'(clr_cnt_q) < 32'(HIST_BINS))) || cmd_i.bin_wr;
  assign bin_waddr = cmd_i.clr ? clr_cnt_q[HB-1:0] : bin_q;
  assign bin_wdata = cmd_i.clr ? '0 : bin_inc;
  assign bin_raddr = cmd_i.walk ? rptr_q : bin_q;

  udh_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_BINS)) u_bins (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (cmd_i.bin_rd || cmd_i.walk),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // report walk: bin data lands in the cycle after its read
  logic                  acc_en_q;
  logic [HB-1:0]         acc_idx_q;
  logic [N_CKPT-1:0]     done_q, pass;
  logic [CKPT_W-1:0]     k_q;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] level_q [N_CKPT];
  logic [COUNT_BITS:0]   run_sum;
  logic [31:0]           pos;

  assign run_sum = {1'b0, run_q} + {1'b0, bin_rdata};
  assign run_d   = run_sum[COUNT_BITS] ? COUNT_MAX : run_sum[COUNT_BITS-1:0];
  assign pos     = 32'(acc_idx_q) * CKPT_SCALE;

  always_comb begin
    for (int k = 0; k < N_CKPT; k++) begin
      pass[k] = pos > (32'(uniq_q) << k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      done_q   <= '0;
      k_q      <= '0;
      rptr_q   <= '0;
    end else begin
      acc_en_q <= cmd_i.walk;
      if (cmd_i.load) begin
        done_q <= '0;
        k_q    <= '0;
        rptr_q <= '0;
      end else begin
        if (cmd_i.walk) rptr_q <= rptr_q + 1'b1;
        if (cmd_i.out_pop) k_q <= k_q + 1'b1;
        if (acc_en_q) done_q <= done_q | pass;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_idx_q <= rptr_q;
    if (cmd_i.load) idx_q <= wrapped[MAP_AW-1:0];
    if (cmd_i.map_upd) bin_q <= bin_d;
    if (cmd_i.load) begin
      run_q <= '0;
      for (int k = 0; k < N_CKPT; k++) level_q[k] <= '0;
    end else if (acc_en_q) begin
      run_q <= run_d;
      // the first bin past a threshold records the running sum
      for (int k = 0; k < N_CKPT; k++) begin
        if (!done_q[k] && pass[k]) level_q[k] <= run_d;
      end
    end
  end

  // result beat
  logic [63:0] level64, total64;

  assign level64 = 64'(level_q[k_q]);
  assign total64 = 64'(run_q);

  assign out_data_o = {5'b0, ovf_q, total64[OUT_CNT_W-1:0], level64[OUT_CNT_W-1:0], k_q};
  assign out_last_o = (k_q == CKPT_LAST);

  assign sts_o.clr_done  = (clr_cnt_q == CLR_W'(CLR_N - 1));
  assign sts_o.hit       = (map_rdata != '0);
  assign sts_o.walk_last = (rptr_q == lim);
  assign sts_o.out_last  = (k_q == CKPT_LAST);

endmodule

// ===== hw/rtl/update_distance_histogram.sv =====
// Reuse-distance histogram of block writes, top level.
// Depends on udh_pkg, udh_ctrl, udh_dp, udh_ram and assert_macros.svh.

// After reset the block sweeps its block map and histogram to zero, one entry
// a cycle, over max(BLOCKS, HIST_BINS) addresses (65536 at the defaults); tready
// stays low meanwhile, config writes are taken. Items are handled one at a
// time. A write beat passes the map read and map update states when the block
// was never written before, and the bin read and bin write-back states too when
// a bin is updated: both the block map and the bin store sit in RAMs with one
// read and one write port and registered read data, so each lookup and each
// read-modify-write takes its own states. A report beat reads one bin per cycle
// over bins 0..min(max_lifespan, HIST_BINS-1), then gives four result beats (10,
// 20, 40, 80 percent). level/total counts saturate; the overflow flag is sticky.
`include "assert_macros.svh"

module update_distance_histogram
  import udh_pkg::*;
#(
  parameter int unsigned BLOCKS     = 65536,
  parameter int unsigned HIST_BINS  = 2048,
  parameter int unsigned SEQ_BITS   = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [15:0] block_address
  input  logic                  s_axis_tuser_i,   // [0] action
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [1:0] checkpoint_index, [33:2] level_count, [65:34] total_count,
  // [66] overflow, [71:67] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  udh_cmd_t cmd;
  udh_sts_t sts;

  assign cfg_ready_o = 1'b1;

  udh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  udh_dp #(
    .BLOCKS     (BLOCKS),
    .HIST_BINS  (HIST_BINS),
    .SEQ_BITS   (SEQ_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_addr_i   (s_axis_tdata_i[ADDR_W-1:0]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  `ASSERT_PROP(a_cmd_excl, clk_i, rst_ni, $onehot0(cmd), "sequencer issued two commands")
  `ASSERT_NEVER(a_in_out_excl, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o, "input open during results")
  `ASSERT_NEVER(a_no_take_in_clear, clk_i, rst_ni, cmd.clr && s_axis_tready_o, "input open during sweep")
  `ASSERT_PROP(a_idle_after_last, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o, "no return to idle after last beat")

endmodule
